// ----- rtl/tsn_pkg.sv -----
`timescale 1ns / 1ps

package tsn_pkg;

    // telnet protocol bytes
    localparam logic [7:0] TN_IAC  = 8'hFF;
    localparam logic [7:0] TN_DONT = 8'hFE;
    localparam logic [7:0] TN_DO   = 8'hFD;
    localparam logic [7:0] TN_WONT = 8'hFC;
    localparam logic [7:0] TN_WILL = 8'hFB;
    localparam logic [7:0] TN_SB   = 8'hFA;
    localparam logic [7:0] TN_SE   = 8'hF0;

    localparam logic [7:0] OP_ECHO  = 8'd1;
    localparam logic [7:0] OP_SGA   = 8'd3;
    localparam logic [7:0] OP_TTYPE = 8'd24;
    localparam logic [7:0] OP_NAWS  = 8'd31;
    localparam logic [7:0] TTYPE_SEND = 8'd1;
    localparam logic [7:0] TTYPE_IS   = 8'd0;

    // input actions
    localparam logic [1:0] ACT_RX     = 2'd0;
    localparam logic [1:0] ACT_USER   = 2'd1;
    localparam logic [1:0] ACT_RESIZE = 2'd2;
    localparam logic [1:0] ACT_START  = 2'd3;

    // pending verb codes, verb byte minus WILL
    localparam logic [1:0] VB_WILL = 2'd0;
    localparam logic [1:0] VB_WONT = 2'd1;
    localparam logic [1:0] VB_DO   = 2'd2;

    localparam logic [15:0] RST_COLUMNS = 16'd80;
    localparam logic [15:0] RST_ROWS    = 16'd24;

    // IS byte followed by the terminal name
    localparam int TNAME_LEN = 15;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef enum logic [2:0] {
        PS_DATA   = 3'd0,
        PS_IAC    = 3'd1,
        PS_NEG    = 3'd2,
        PS_SB     = 3'd3,
        PS_SB_IAC = 3'd4
    } t_pstate;

    typedef enum logic [2:0] {
        TK_DATA,
        TK_USER,
        TK_CMD,
        TK_CMDWIN,
        TK_WIN,
        TK_TTYPE
    } t_kind;

    typedef enum logic [2:0] {
        BS_FIRST,
        BS_DUP,
        BS_CMD,
        BS_SBHDR,
        BS_WVAL,
        BS_TNAME,
        BS_TAIL
    } t_bstate;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [15:0] cols;
        logic [15:0] rows;
    } t_tok;

    typedef struct packed {
        logic push;
        t_tok tok;
    } t_qwr;

    typedef struct packed {
        logic valid;
        t_tok tok;
    } t_qrd;

    function automatic logic [7:0] tn_name_char(input logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:    c = TTYPE_IS;
            4'd1:    c = "x";
            4'd2:    c = "t";
            4'd3:    c = "e";
            4'd4:    c = "r";
            4'd5:    c = "m";
            4'd6:    c = "-";
            4'd7:    c = "2";
            4'd8:    c = "5";
            4'd9:    c = "6";
            4'd10:   c = "c";
            4'd11:   c = "o";
            4'd12:   c = "l";
            4'd13:   c = "o";
            4'd14:   c = "r";
            default: c = 8'd0;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/tsn_if.sv -----
`timescale 1ns / 1ps

interface tsn_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [7:0]  in_byte;
    logic [15:0] new_columns;
    logic [15:0] new_rows;

    modport source (output valid, action, in_byte, new_columns, new_rows, input ready);
    modport sink   (input valid, action, in_byte, new_columns, new_rows, output ready);
endinterface

interface tsn_out_if;
    logic       valid;
    logic       ready;
    logic       destination;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, destination, out_byte, last, input ready);
    modport sink   (input valid, destination, out_byte, last, output ready);
endinterface

// ----- rtl/telnet_stream_negotiator_core.sv -----
`timescale 1ns / 1ps

// channel   dir  transfer when   payload
// i_in      in   valid && ready  action, in_byte, new_columns, new_rows
// o_out     out  valid && ready  destination, out_byte, last
//
// the front parses one item per cycle while the queue is not full and pushes
// at most one token into a four-entry queue; the back expands a token into its
// bytes, one per cycle while o_out is not stalled; a data byte passes through
// the queue and then the o_out stage; a reply has 3 bytes for a verb reply,
// up to 13 for a window report, up to 16 for DO NAWS with its report, 20 for
// the terminal type; i_in.ready drops only while the queue is full;
// o_out is a registered stage; reset is synchronous, with no clearing pass

module telnet_stream_negotiator_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tsn_in_if.sink    i_in,
    tsn_out_if.source o_out
);
    import tsn_pkg::*;

    t_qwr wr;
    t_qrd rd;
    logic full;
    logic pop;

    tsn_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_wr    (wr)
    );

    tsn_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .o_full  (full),
        .i_pop   (pop),
        .o_rd    (rd)
    );

    tsn_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd    (rd),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

// ----- rtl/tsn_front.sv -----
`timescale 1ns / 1ps

module tsn_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    tsn_in_if.sink         i_in,
    input  logic           i_full,
    output tsn_pkg::t_qwr  o_wr
);
    import tsn_pkg::*;

    t_pstate     r_ps,    n_ps;
    logic [1:0]  r_verb,  n_verb;
    logic [1:0]  r_sblen, n_sblen;
    logic [7:0]  r_sbopt, n_sbopt;
    logic [7:0]  r_sbsec, n_sbsec;
    logic        r_naws,  n_naws;
    logic [15:0] r_cols,  n_cols;
    logic [15:0] r_rows,  n_rows;

    logic       acc;
    logic [7:0] b;

    assign i_in.ready = !i_full;
    assign acc        = i_in.valid && !i_full;
    assign b          = i_in.in_byte;

    // next state
    always_comb begin
        n_ps    = r_ps;
        n_verb  = r_verb;
        n_sblen = r_sblen;
        n_sbopt = r_sbopt;
        n_sbsec = r_sbsec;
        n_naws  = r_naws;
        n_cols  = r_cols;
        n_rows  = r_rows;
        if (acc) begin
            unique case (i_in.action)
                ACT_RX: begin
                    unique case (r_ps)
                        PS_IAC: begin
                            if (b == TN_IAC) begin
                                n_ps = PS_DATA;
                            end else if (b >= TN_WILL && b <= TN_DONT) begin
                                n_verb = b[1:0] + 2'd1;
                                n_ps   = PS_NEG;
                            end else if (b == TN_SB) begin
                                n_sblen = 2'd0;
                                n_sbopt = 8'd0;
                                n_sbsec = 8'd0;
                                n_ps    = PS_SB;
                            end else begin
                                n_ps = PS_DATA;
                            end
                        end
                        PS_NEG: begin
                            if (r_verb == VB_DO && b == OP_NAWS) begin
                                n_naws = 1'b1;
                            end else if (r_verb == VB_WONT && b == OP_NAWS) begin
                                n_naws = 1'b0;
                            end
                            n_ps = PS_DATA;
                        end
                        PS_SB, PS_SB_IAC: begin
                            if (r_ps == PS_SB && b == TN_IAC) begin
                                n_ps = PS_SB_IAC;
                            end else if (r_ps == PS_SB_IAC && b != TN_IAC) begin
                                n_ps = PS_DATA;
                            end else begin
                                // body byte, or escaped IAC inside the body
                                n_ps = PS_SB;
                                if (r_sblen == 2'd0) begin
                                    n_sbopt = b;
                                    n_sblen = 2'd1;
                                end else if (r_sblen == 2'd1) begin
                                    n_sbsec = b;
                                    n_sblen = 2'd2;
                                end
                            end
                        end
                        default: begin
                            if (b == TN_IAC) begin
                                n_ps = PS_IAC;
                            end
                        end
                    endcase
                end
                ACT_USER: begin
                end
                ACT_RESIZE: begin
                    n_cols = i_in.new_columns;
                    n_rows = i_in.new_rows;
                end
                default: begin
                    n_ps    = PS_DATA;
                    n_sblen = 2'd0;
                    n_sbopt = 8'd0;
                    n_sbsec = 8'd0;
                    n_naws  = 1'b0;
                end
            endcase
        end
    end

    // token to the back end
    always_comb begin
        o_wr.push     = 1'b0;
        o_wr.tok.kind = TK_DATA;
        o_wr.tok.b0   = b;
        o_wr.tok.b1   = b;
        o_wr.tok.cols = r_cols;
        o_wr.tok.rows = r_rows;
        if (acc) begin
            unique case (i_in.action)
                ACT_RX: begin
                    unique case (r_ps)
                        PS_IAC: begin
                            if (b == TN_IAC) begin
                                o_wr.push = 1'b1;
                            end
                        end
                        PS_NEG: begin
                            o_wr.tok.kind = TK_CMD;
                            if (r_verb == VB_WILL) begin
                                o_wr.push   = 1'b1;
                                o_wr.tok.b0 = (b == OP_ECHO || b == OP_SGA) ? TN_DO
                                                                            : TN_DONT;
                            end else if (r_verb == VB_DO) begin
                                o_wr.push = 1'b1;
                                if (b == OP_NAWS) begin
                                    o_wr.tok.kind = TK_CMDWIN;
                                    o_wr.tok.b0   = TN_WILL;
                                end else if (b == OP_TTYPE) begin
                                    o_wr.tok.b0 = TN_WILL;
                                end else begin
                                    o_wr.tok.b0 = TN_WONT;
                                end
                            end
                        end
                        PS_SB: begin
                        end
                        PS_SB_IAC: begin
                            o_wr.tok.kind = TK_TTYPE;
                            o_wr.push     = (b == TN_SE) && (r_sblen == 2'd2) &&
                                            (r_sbopt == OP_TTYPE) && (r_sbsec == TTYPE_SEND);
                        end
                        default: begin
                            o_wr.push = (b != TN_IAC);
                        end
                    endcase
                end
                ACT_USER: begin
                    o_wr.push     = 1'b1;
                    o_wr.tok.kind = TK_USER;
                end
                ACT_RESIZE: begin
                    o_wr.push     = r_naws;
                    o_wr.tok.kind = TK_WIN;
                    o_wr.tok.cols = i_in.new_columns;
                    o_wr.tok.rows = i_in.new_rows;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ps    <= PS_DATA;
            r_verb  <= 2'd0;
            r_sblen <= 2'd0;
            r_sbopt <= 8'd0;
            r_sbsec <= 8'd0;
            r_naws  <= 1'b0;
            r_cols  <= RST_COLUMNS;
            r_rows  <= RST_ROWS;
        end else begin
            r_ps    <= n_ps;
            r_verb  <= n_verb;
            r_sblen <= n_sblen;
            r_sbopt <= n_sbopt;
            r_sbsec <= n_sbsec;
            r_naws  <= n_naws;
            r_cols  <= n_cols;
            r_rows  <= n_rows;
        end
    end

endmodule

// ----- rtl/tsn_queue.sv -----
`timescale 1ns / 1ps

module tsn_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tsn_pkg::t_qwr  i_wr,
    output logic           o_full,
    input  logic           i_pop,
    output tsn_pkg::t_qrd  o_rd
);
    import tsn_pkg::*;

    t_tok           r_mem [QDEPTH];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QAW:0]   r_cnt;

    assign o_full     = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_rd.valid = (r_cnt != '0);
    assign o_rd.tok   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_wr.push) begin
            r_mem[r_wp] <= i_wr.tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr.push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            unique case ({i_wr.push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- rtl/tsn_back.sv -----
`timescale 1ns / 1ps

module tsn_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tsn_pkg::t_qrd  i_rd,
    output logic           o_pop,
    tsn_out_if.source      o_out
);
    import tsn_pkg::*;

    t_bstate    r_bs,  n_bs;
    logic [3:0] r_idx, n_idx;
    logic       r_dup, n_dup;

    logic       r_ov;
    logic       r_odest;
    logic [7:0] r_obyte;
    logic       r_olast;

    logic       adv, step;
    logic       e_valid, e_dest, e_end;
    logic [7:0] e_byte;
    logic [7:0] wsel;
    t_tok       tok;

    assign tok  = i_rd.tok;
    assign adv  = !r_ov || o_out.ready;
    assign step = adv && e_valid;

    always_comb begin
        unique case (r_idx[1:0])
            2'd0:    wsel = tok.cols[15:8];
            2'd1:    wsel = tok.cols[7:0];
            2'd2:    wsel = tok.rows[15:8];
            default: wsel = tok.rows[7:0];
        endcase
    end

    // byte for the current step of the head token
    always_comb begin
        e_valid = i_rd.valid;
        e_dest  = 1'b1;
        e_byte  = TN_IAC;
        e_end   = 1'b0;
        unique case (r_bs)
            BS_FIRST: begin
                unique case (tok.kind)
                    TK_DATA: begin
                        e_dest = 1'b0;
                        e_byte = tok.b0;
                        e_end  = 1'b1;
                    end
                    TK_USER: begin
                        e_byte = tok.b0;
                        e_end  = (tok.b0 != TN_IAC);
                    end
                    default: begin
                        e_byte = TN_IAC;
                    end
                endcase
            end
            BS_DUP: begin
                e_end = 1'b1;
            end
            BS_CMD: begin
                e_byte = r_idx[1] ? tok.b1 : tok.b0;
                e_end  = r_idx[1] && (tok.kind == TK_CMD);
            end
            BS_SBHDR: begin
                unique case (r_idx[1:0])
                    2'd0:    e_byte = TN_IAC;
                    2'd1:    e_byte = TN_SB;
                    default: e_byte = (tok.kind == TK_TTYPE) ? OP_TTYPE : OP_NAWS;
                endcase
            end
            BS_WVAL: begin
                e_byte = wsel;
            end
            BS_TNAME: begin
                e_byte = tn_name_char(r_idx);
            end
            default: begin
                e_byte = r_idx[0] ? TN_SE : TN_IAC;
                e_end  = r_idx[0];
            end
        endcase
    end

    assign o_pop = step && e_end;

    // sequencer next state
    always_comb begin
        n_bs  = r_bs;
        n_idx = r_idx;
        n_dup = r_dup;
        if (step) begin
            unique case (r_bs)
                BS_FIRST: begin
                    unique case (tok.kind)
                        TK_DATA: begin
                        end
                        TK_USER: begin
                            if (tok.b0 == TN_IAC) begin
                                n_bs = BS_DUP;
                            end
                        end
                        TK_CMD, TK_CMDWIN: begin
                            n_bs  = BS_CMD;
                            n_idx = 4'd1;
                        end
                        default: begin
                            n_bs  = BS_SBHDR;
                            n_idx = 4'd1;
                        end
                    endcase
                end
                BS_DUP: begin
                    n_bs = BS_FIRST;
                end
                BS_CMD: begin
                    if (r_idx == 4'd2) begin
                        n_idx = 4'd0;
                        n_bs  = (tok.kind == TK_CMDWIN) ? BS_SBHDR : BS_FIRST;
                    end else begin
                        n_idx = r_idx + 4'd1;
                    end
                end
                BS_SBHDR: begin
                    if (r_idx == 4'd2) begin
                        n_idx = 4'd0;
                        n_dup = 1'b0;
                        n_bs  = (tok.kind == TK_TTYPE) ? BS_TNAME : BS_WVAL;
                    end else begin
                        n_idx = r_idx + 4'd1;
                    end
                end
                BS_WVAL: begin
                    // an IAC size byte goes out twice
                    if (wsel == TN_IAC && !r_dup) begin
                        n_dup = 1'b1;
                    end else begin
                        n_dup = 1'b0;
                        if (r_idx == 4'd3) begin
                            n_idx = 4'd0;
                            n_bs  = BS_TAIL;
                        end else begin
                            n_idx = r_idx + 4'd1;
                        end
                    end
                end
                BS_TNAME: begin
                    if (r_idx == 4'(TNAME_LEN - 1)) begin
                        n_idx = 4'd0;
                        n_bs  = BS_TAIL;
                    end else begin
                        n_idx = r_idx + 4'd1;
                    end
                end
                default: begin
                    if (r_idx[0]) begin
                        n_idx = 4'd0;
                        n_bs  = BS_FIRST;
                    end else begin
                        n_idx = r_idx + 4'd1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bs  <= BS_FIRST;
            r_idx <= 4'd0;
            r_dup <= 1'b0;
            r_ov  <= 1'b0;
        end else begin
            r_bs  <= n_bs;
            r_idx <= n_idx;
            r_dup <= n_dup;
            if (adv) begin
                r_ov <= e_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_odest <= e_dest;
            r_obyte <= e_byte;
            r_olast <= e_end;
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.destination = r_odest;
    assign o_out.out_byte    = r_obyte;
    assign o_out.last        = r_olast;

endmodule

// ----- verif/telnet_stream_negotiator_core_tb.sv -----
`timescale 1ns / 1ps

module telnet_stream_negotiator_core_tb;
    import tsn_pkg::*;

    localparam logic       TO_TERMINAL = 1'b0;
    localparam logic       TO_REMOTE   = 1'b1;
    localparam logic [7:0] TN_GA       = 8'hF9;
    localparam int         MAX_RESULTS = 20;
    localparam int         HOLD_CYCLES = 400;
    localparam int         TERM_LEN    = 14;
    localparam logic [8*TERM_LEN-1:0] TERM_NAME = "xterm-256color";

    typedef struct packed {
        logic       dest;
        logic [7:0] octet;
        logic       last;
    } t_reply;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tsn_in_if  in_if ();
    tsn_out_if out_if ();

    telnet_stream_negotiator_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #10 i_clk = ~i_clk;

    // shadow of the negotiator state
    t_pstate     parse_st;
    logic [1:0]  verb_held;
    logic [1:0]  body_len;
    logic [7:0]  body_opt;
    logic [7:0]  body_arg;
    logic        naws_on;
    logic [15:0] win_cols;
    logic [15:0] win_rows;

    t_reply awaited_bytes[$];
    int     item_results;
    int     items_sent;
    int     errors;
    int     tx_idle_pct;
    int     rx_idle_pct;
    int     hold_requests;

    function automatic logic [7:0] rand8();
        logic [31:0] r;
        r = $urandom;
        return r[7:0];
    endfunction

    function automatic logic [15:0] rand16();
        logic [31:0] r;
        r = $urandom;
        return r[15:0];
    endfunction

    function automatic logic [7:0] pick_option();
        case ($urandom_range(5))
            0: return OP_ECHO;
            1: return OP_SGA;
            2: return OP_TTYPE;
            3: return OP_NAWS;
            default: return rand8();
        endcase
    endfunction

    function automatic logic [15:0] pick_size();
        case ($urandom_range(4))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h00FF;
            3: return 16'hFF00;
            default: return rand16();
        endcase
    endfunction

    function void queue_byte(input logic dest, input logic [7:0] b);
        t_reply r;
        if (item_results < MAX_RESULTS) begin
            r.dest  = dest;
            r.octet = b;
            r.last  = 1'b0;
            awaited_bytes.push_back(r);
            item_results++;
        end
    endfunction

    function void queue_escaped(input logic [7:0] b);
        queue_byte(TO_REMOTE, b);
        if (b == TN_IAC)
            queue_byte(TO_REMOTE, TN_IAC);
    endfunction

    function void queue_cmd(input logic [7:0] verb, input logic [7:0] opt);
        queue_byte(TO_REMOTE, TN_IAC);
        queue_byte(TO_REMOTE, verb);
        queue_byte(TO_REMOTE, opt);
    endfunction

    function void queue_window();
        if (naws_on) begin
            queue_byte(TO_REMOTE, TN_IAC);
            queue_byte(TO_REMOTE, TN_SB);
            queue_byte(TO_REMOTE, OP_NAWS);
            queue_escaped(win_cols[15:8]);
            queue_escaped(win_cols[7:0]);
            queue_escaped(win_rows[15:8]);
            queue_escaped(win_rows[7:0]);
            queue_byte(TO_REMOTE, TN_IAC);
            queue_byte(TO_REMOTE, TN_SE);
        end
    endfunction

    function void answer_verb(input logic [7:0] opt);
        case (verb_held)
            VB_WILL: begin
                if (opt == OP_ECHO || opt == OP_SGA)
                    queue_cmd(TN_DO, opt);
                else
                    queue_cmd(TN_DONT, opt);
            end
            VB_DO: begin
                if (opt == OP_NAWS) begin
                    queue_cmd(TN_WILL, opt);
                    naws_on = 1'b1;
                    queue_window();
                end else if (opt == OP_TTYPE) begin
                    queue_cmd(TN_WILL, opt);
                end else begin
                    queue_cmd(TN_WONT, opt);
                end
            end
            VB_WONT: begin
                if (opt == OP_NAWS)
                    naws_on = 1'b0;
            end
            default: ;
        endcase
    endfunction

    function void keep_body(input logic [7:0] b);
        if (body_len == 2'd0) begin
            body_opt = b;
            body_len = 2'd1;
        end else if (body_len == 2'd1) begin
            body_arg = b;
            body_len = 2'd2;
        end
    endfunction

    function void clear_body();
        body_len = 2'd0;
        body_opt = 8'd0;
        body_arg = 8'd0;
    endfunction

    function void finish_subneg();
        int i;
        if (body_len == 2'd2 && body_opt == OP_TTYPE && body_arg == TTYPE_SEND) begin
            queue_byte(TO_REMOTE, TN_IAC);
            queue_byte(TO_REMOTE, TN_SB);
            queue_byte(TO_REMOTE, OP_TTYPE);
            queue_escaped(TTYPE_IS);
            for (i = 0; i < TERM_LEN; i++)
                queue_escaped(TERM_NAME[8*(TERM_LEN-1-i) +: 8]);
            queue_byte(TO_REMOTE, TN_IAC);
            queue_byte(TO_REMOTE, TN_SE);
        end
    endfunction

    function void parse_rx_byte(input logic [7:0] b);
        logic [7:0] diff;
        case (parse_st)
            PS_IAC: begin
                if (b == TN_IAC) begin
                    queue_byte(TO_TERMINAL, TN_IAC);
                    parse_st = PS_DATA;
                end else if (b >= TN_WILL && b <= TN_DONT) begin
                    diff = b - TN_WILL;
                    verb_held = diff[1:0];
                    parse_st = PS_NEG;
                end else if (b == TN_SB) begin
                    clear_body();
                    parse_st = PS_SB;
                end else begin
                    parse_st = PS_DATA;
                end
            end
            PS_NEG: begin
                answer_verb(b);
                parse_st = PS_DATA;
            end
            PS_SB: begin
                if (b == TN_IAC)
                    parse_st = PS_SB_IAC;
                else
                    keep_body(b);
            end
            PS_SB_IAC: begin
                if (b == TN_SE) begin
                    finish_subneg();
                    parse_st = PS_DATA;
                end else if (b == TN_IAC) begin
                    keep_body(TN_IAC);
                    parse_st = PS_SB;
                end else begin
                    parse_st = PS_DATA;
                end
            end
            default: begin
                if (b == TN_IAC)
                    parse_st = PS_IAC;
                else
                    queue_byte(TO_TERMINAL, b);
            end
        endcase
    endfunction

    // works out every byte one accepted item produces and queues it
    function void apply_telnet_item(input logic [1:0] act, input logic [7:0] b,
                                    input logic [15:0] cols, input logic [15:0] rows);
        t_reply r;
        item_results = 0;
        case (act)
            ACT_RX:   parse_rx_byte(b);
            ACT_USER: queue_escaped(b);
            ACT_RESIZE: begin
                win_cols = cols;
                win_rows = rows;
                queue_window();
            end
            default: begin
                parse_st = PS_DATA;
                clear_body();
                naws_on = 1'b0;
            end
        endcase
        if (item_results > 0) begin
            r = awaited_bytes.pop_back();
            r.last = 1'b1;
            awaited_bytes.push_back(r);
        end
    endfunction

    // predicted before the offer: the item is held until it transfers
    task automatic send_item(input logic [1:0] act, input logic [7:0] b,
                             input logic [15:0] cols, input logic [15:0] rows);
        apply_telnet_item(act, b, cols, rows);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.action      <= act;
        in_if.in_byte     <= b;
        in_if.new_columns <= cols;
        in_if.new_rows    <= rows;
        @(posedge i_clk);
        while (!in_if.ready)
            @(posedge i_clk);
        items_sent++;
    endtask

    task automatic rx(input logic [7:0] b);
        send_item(ACT_RX, b, rand16(), rand16());
    endtask

    task automatic wait_results_drained();
        in_if.valid <= 1'b0;
        while (awaited_bytes.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic test_directed();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        // doubled IAC becomes one data byte
        rx(TN_IAC);
        rx(TN_IAC);
        send_item(ACT_USER, TN_IAC, 16'h0000, 16'hFFFF);
        // DO NAWS reports the reset window size
        rx(TN_IAC);
        rx(TN_DO);
        rx(OP_NAWS);
        send_item(ACT_RESIZE, 8'h00, 16'hFFFF, 16'h0000);
        rx(TN_IAC);
        rx(TN_WONT);
        rx(OP_NAWS);
        // resize with NAWS off stays silent
        send_item(ACT_RESIZE, 8'hFF, 16'h0000, 16'hFFFF);
        // long TTYPE SEND body, third byte dropped
        rx(TN_IAC);
        rx(TN_SB);
        rx(OP_TTYPE);
        rx(TTYPE_SEND);
        rx(8'h07);
        rx(TN_IAC);
        rx(TN_SE);
        // empty subnegotiation
        rx(TN_IAC);
        rx(TN_SB);
        rx(TN_IAC);
        rx(TN_SE);
        // bad end of body
        rx(TN_IAC);
        rx(TN_SB);
        rx(OP_TTYPE);
        rx(TN_IAC);
        rx(8'h00);
        // GA is ignored
        rx(TN_IAC);
        rx(TN_GA);
        // session start inside a body, next byte is plain data
        rx(TN_IAC);
        rx(TN_SB);
        rx(OP_TTYPE);
        send_item(ACT_START, rand8(), rand16(), rand16());
        rx(8'h00);
    endtask

    task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int count);
        int         target;
        int         pick;
        int         len;
        int         i;
        logic [7:0] b;
        logic [7:0] act_bits;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        target = items_sent + count;
        while (items_sent < target) begin
            pick = $urandom_range(99);
            if (pick < 25) begin
                rx(rand8());
            end else if (pick < 33) begin
                rx(TN_IAC);
                rx(TN_IAC);
            end else if (pick < 43) begin
                b = ($urandom_range(3) == 0) ? TN_IAC : rand8();
                send_item(ACT_USER, b, rand16(), rand16());
            end else if (pick < 63) begin
                rx(TN_IAC);
                case ($urandom_range(3))
                    0: rx(TN_WILL);
                    1: rx(TN_WONT);
                    2: rx(TN_DO);
                    default: rx(TN_DONT);
                endcase
                rx(pick_option());
            end else if (pick < 78) begin
                rx(TN_IAC);
                rx(TN_SB);
                len = $urandom_range(4);
                for (i = 0; i < len; i++) begin
                    if (i == 0 && $urandom_range(9) < 7)
                        b = OP_TTYPE;
                    else if (i == 1 && $urandom_range(9) < 7)
                        b = TTYPE_SEND;
                    else
                        b = rand8();
                    rx(b);
                    if (b == TN_IAC)
                        rx(TN_IAC);
                end
                rx(TN_IAC);
                if ($urandom_range(99) < 85)
                    rx(TN_SE);
                else
                    rx(rand8());
            end else if (pick < 84) begin
                rx(TN_IAC);
                b = 8'($urandom_range(TN_GA, TN_SE));
                rx(b);
            end else if (pick < 92) begin
                send_item(ACT_RESIZE, rand8(), pick_size(), pick_size());
            end else if (pick < 95) begin
                send_item(ACT_START, rand8(), rand16(), rand16());
            end else begin
                act_bits = rand8();
                send_item(act_bits[1:0], rand8(), rand16(), rand16());
            end
        end
    endtask

    task automatic test_output_stall();
        int k;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_requests++;
        // long replies pile up behind the stalled output
        rx(TN_IAC);
        rx(TN_DO);
        rx(OP_NAWS);
        for (k = 0; k < 6; k++) begin
            rx(TN_IAC);
            rx(TN_SB);
            rx(OP_TTYPE);
            rx(TTYPE_SEND);
            rx(TN_IAC);
            rx(TN_SE);
        end
    endtask

    // output side: checks each transfer, then picks the next ready
    initial begin : result_side
        t_reply want;
        int     hold_left;
        int     hold_seen;
        hold_left = 0;
        hold_seen = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_if.valid && out_if.ready) begin
                if (awaited_bytes.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result dest %0d byte %02h last %0d", $time,
                             out_if.destination, out_if.out_byte, out_if.last);
                end else begin
                    want = awaited_bytes.pop_front();
                    if (want.dest !== out_if.destination || want.octet !== out_if.out_byte ||
                        want.last !== out_if.last) begin
                        errors++;
                        $display("%0t: expected %0d %02h %0d, actual %0d %02h %0d",
                                 $time, want.dest, want.octet, want.last,
                                 out_if.destination, out_if.out_byte, out_if.last);
                    end
                end
            end
            if (hold_seen != hold_requests) begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else if (rx_idle_pct != 0 && $urandom_range(99) < rx_idle_pct) begin
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        #10_000_000;
        $display("telnet_stream_negotiator_core_tb NOT OK");
        $finish;
    end

    initial begin
        parse_st      = PS_DATA;
        verb_held     = 2'd0;
        clear_body();
        naws_on       = 1'b0;
        win_cols      = RST_COLUMNS;
        win_rows      = RST_ROWS;
        items_sent    = 0;
        errors        = 0;
        tx_idle_pct   = 0;
        rx_idle_pct   = 0;
        hold_requests = 0;

        i_rst_n           <= 1'b0;
        in_if.valid       <= 1'b0;
        in_if.action      <= ACT_RX;
        in_if.in_byte     <= 8'd0;
        in_if.new_columns <= 16'd0;
        in_if.new_rows    <= 16'd0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        wait_results_drained();
        test_random_traffic(18, 87, 100);
        test_random_traffic(87, 18, 100);
        wait_results_drained();
        test_random_traffic(0, 0, 100);
        test_output_stall();
        wait_results_drained();

        repeat (40) @(posedge i_clk);
        if (errors == 0 && awaited_bytes.size() == 0) begin
            $display("telnet_stream_negotiator_core_tb OK");
        end else begin
            $display("telnet_stream_negotiator_core_tb NOT OK");
        end
        $finish;
    end

endmodule
